@@ design/node_lock_fcfs_sjf_arbiter_macros.svh @@
// ---------------------------------------------------------------------------
// Node lock arbiter assertion macros
// Concurrent assertion shorthands clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef NODE_LOCK_FCFS_SJF_ARBITER_MACROS_SVH
`define NODE_LOCK_FCFS_SJF_ARBITER_MACROS_SVH

// same-cycle implication
`define NLA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define NLA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ design/nla_pkg.sv @@
// ---------------------------------------------------------------------------
// Node lock arbiter package
// Sizes, stored record layouts, command codes and sequencer states.
// ---------------------------------------------------------------------------
package nla_pkg;

    localparam int NODE_COUNT  = 64;
    localparam int QUEUE_DEPTH = 32;

    localparam int NODE_IN_W = 6;
    localparam int TRAV_W    = 5;
    localparam int REM_W     = 7;

    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
    localparam int LEN_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_AW    = NODE_W + QIDX_W;
    localparam int ENTRY_DEPTH = NODE_COUNT * (2 ** QIDX_W);

    localparam logic CMD_ENTER = 1'b0;
    localparam logic CMD_LEAVE = 1'b1;

    localparam logic MODE_FCFS = 1'b0;
    localparam logic MODE_SJF  = 1'b1;

    typedef struct packed {
        logic [TRAV_W-1:0] traveler;
        logic [REM_W-1:0]  remaining;
    } entry_t;

    typedef struct packed {
        logic             occupied;
        logic [LEN_W-1:0] length;
    } nstate_t;

    localparam int ENTRY_W  = $bits(entry_t);
    localparam int NSTATE_W = $bits(nstate_t);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_NODE  = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_SHIFT = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

@@ design/nla_ram.sv @@
// ---------------------------------------------------------------------------
// Node lock arbiter RAM
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module nla_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/node_lock_fcfs_sjf_arbiter.sv @@
// ---------------------------------------------------------------------------
// Node lock arbiter
// Per-node lock with a wait queue, handed over oldest first or shortest
// remaining path first.
// ---------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       in_valid / in_stall       cmd, node, traveler, remaining
//  out      out_valid / out_stall     granted, grant_traveler, grant_node,
//                                     queue_overflow
//  cfg      cfg_wr_en                 cfg_wr_data (sched_mode)
//
//  An enter or an empty leave goes from transfer via ST_NODE and ST_DONE to
//  the registered result. A leave with waiters reads them in ST_SCAN, all in
//  SJF mode and only the head in FCFS mode, then shifts the entries after the
//  pick down in ST_SHIFT, one entry per cycle on the single queue RAM read port.
//  Reset clears all locks and queue lengths at once; no clearing pass.
//  A stalled result holds the sequencer in its last state.
// ---------------------------------------------------------------------------
`include "node_lock_fcfs_sjf_arbiter_macros.svh"

module node_lock_fcfs_sjf_arbiter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           cmd,
    input  logic [nla_pkg::NODE_IN_W-1:0]  node,
    input  logic [nla_pkg::TRAV_W-1:0]     traveler,
    input  logic [nla_pkg::REM_W-1:0]      remaining,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           granted,
    output logic [nla_pkg::TRAV_W-1:0]     grant_traveler,
    output logic [nla_pkg::NODE_IN_W-1:0]  grant_node,
    output logic                           queue_overflow
);

    nla_pkg::state_t                    state_reg, state_next;
    logic                               mode_reg;
    logic [nla_pkg::NODE_COUNT-1:0]     node_valid_reg, node_valid_next;
    logic                               out_valid_reg, out_valid_next;

    logic                               cmd_reg;
    logic [nla_pkg::NODE_IN_W-1:0]      node_reg;
    logic [nla_pkg::TRAV_W-1:0]         trav_reg;
    logic [nla_pkg::REM_W-1:0]          rem_reg;
    logic [nla_pkg::LEN_W-1:0]          len_reg, len_next;
    logic [nla_pkg::LEN_W-1:0]          scan_len_reg, scan_len_next;
    logic [nla_pkg::LEN_W-1:0]          rd_idx_reg, rd_idx_next;
    logic [nla_pkg::LEN_W-1:0]          cmp_idx_reg, cmp_idx_next;
    logic [nla_pkg::LEN_W-1:0]          best_idx_reg, best_idx_next;
    logic [nla_pkg::REM_W-1:0]          best_rem_reg, best_rem_next;
    logic [nla_pkg::TRAV_W-1:0]         best_trav_reg, best_trav_next;
    logic                               pend_granted_reg, pend_granted_next;
    logic [nla_pkg::TRAV_W-1:0]         pend_trav_reg, pend_trav_next;
    logic [nla_pkg::NODE_IN_W-1:0]      pend_node_reg, pend_node_next;
    logic                               pend_ovf_reg, pend_ovf_next;
    logic                               granted_reg, granted_next;
    logic [nla_pkg::TRAV_W-1:0]         grant_traveler_reg, grant_traveler_next;
    logic [nla_pkg::NODE_IN_W-1:0]      grant_node_reg, grant_node_next;
    logic                               queue_overflow_reg, queue_overflow_next;

    logic                               in_xfer;
    logic                               node_ok;
    logic [nla_pkg::NODE_W-1:0]         node_a;
    nla_pkg::nstate_t                   ns;
    nla_pkg::entry_t                    entry_q;
    logic                               scan_take;
    logic [nla_pkg::LEN_W-1:0]          sel_idx;
    logic [nla_pkg::LEN_W-1:0]          sel_next;
    logic [nla_pkg::TRAV_W-1:0]         sel_trav;
    logic [nla_pkg::LEN_W-1:0]          shift_next;

    logic                               ns_wr_en;
    nla_pkg::nstate_t                   ns_wr_data;
    logic [nla_pkg::NSTATE_W-1:0]       ns_rd_data;

    logic                               ent_wr_en;
    logic [nla_pkg::QIDX_W-1:0]         ent_wr_idx;
    nla_pkg::entry_t                    ent_wr_data;
    logic                               ent_rd_en;
    logic [nla_pkg::QIDX_W-1:0]         ent_rd_idx;
    logic [nla_pkg::ENTRY_W-1:0]        ent_rd_data;

    assign in_stall = (state_reg != nla_pkg::ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;

    assign out_valid      = out_valid_reg;
    assign granted        = granted_reg;
    assign grant_traveler = grant_traveler_reg;
    assign grant_node     = grant_node_reg;
    assign queue_overflow = queue_overflow_reg;

    assign node_ok = (int'(node_reg) < nla_pkg::NODE_COUNT);
    assign node_a  = nla_pkg::NODE_W'(node_reg);
    assign ns      = node_valid_reg[node_a] ? nla_pkg::nstate_t'(ns_rd_data) : '0;
    assign entry_q = nla_pkg::entry_t'(ent_rd_data);

    assign scan_take  = (cmp_idx_reg == '0) || (entry_q.remaining < best_rem_reg);
    assign sel_idx    = scan_take ? cmp_idx_reg : best_idx_reg;
    assign sel_trav   = scan_take ? entry_q.traveler : best_trav_reg;
    assign sel_next   = sel_idx + nla_pkg::LEN_W'(1);
    assign shift_next = rd_idx_reg + nla_pkg::LEN_W'(1);

    nla_ram #(
        .WIDTH (nla_pkg::NSTATE_W),
        .DEPTH (nla_pkg::NODE_COUNT)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (ns_wr_en),
        .wr_addr (node_a),
        .wr_data (ns_wr_data),
        .rd_en   (in_xfer),
        .rd_addr (nla_pkg::NODE_W'(node)),
        .rd_data (ns_rd_data)
    );

    nla_ram #(
        .WIDTH (nla_pkg::ENTRY_W),
        .DEPTH (nla_pkg::ENTRY_DEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (ent_wr_en),
        .wr_addr ({node_a, ent_wr_idx}),
        .wr_data (ent_wr_data),
        .rd_en   (ent_rd_en),
        .rd_addr ({node_a, ent_rd_idx}),
        .rd_data (ent_rd_data)
    );

    always_comb
    begin
        state_next          = state_reg;
        node_valid_next     = node_valid_reg;
        out_valid_next      = out_valid_reg && out_stall;
        len_next            = len_reg;
        scan_len_next       = scan_len_reg;
        rd_idx_next         = rd_idx_reg;
        cmp_idx_next        = cmp_idx_reg;
        best_idx_next       = best_idx_reg;
        best_rem_next       = best_rem_reg;
        best_trav_next      = best_trav_reg;
        pend_granted_next   = pend_granted_reg;
        pend_trav_next      = pend_trav_reg;
        pend_node_next      = pend_node_reg;
        pend_ovf_next       = pend_ovf_reg;
        granted_next        = granted_reg;
        grant_traveler_next = grant_traveler_reg;
        grant_node_next     = grant_node_reg;
        queue_overflow_next = queue_overflow_reg;
        ns_wr_en            = 1'b0;
        ns_wr_data          = '0;
        ent_wr_en           = 1'b0;
        ent_wr_idx          = '0;
        ent_wr_data         = '0;
        ent_rd_en           = 1'b0;
        ent_rd_idx          = '0;

        unique case (state_reg)
            nla_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = nla_pkg::ST_NODE;
                end
            end

            nla_pkg::ST_NODE:
            begin
                pend_granted_next = 1'b0;
                pend_trav_next    = '0;
                pend_node_next    = '0;
                pend_ovf_next     = 1'b0;
                state_next        = nla_pkg::ST_DONE;
                if (node_ok)
                begin
                    if (cmd_reg == nla_pkg::CMD_ENTER)
                    begin
                        if (!ns.occupied)
                        begin
                            ns_wr_en          = 1'b1;
                            ns_wr_data        = '{occupied: 1'b1, length: ns.length};
                            node_valid_next[node_a] = 1'b1;
                            pend_granted_next = 1'b1;
                            pend_trav_next    = trav_reg;
                            pend_node_next    = node_reg;
                        end
                        else if (ns.length < nla_pkg::LEN_W'(nla_pkg::QUEUE_DEPTH))
                        begin
                            ent_wr_en   = 1'b1;
                            ent_wr_idx  = ns.length[nla_pkg::QIDX_W-1:0];
                            ent_wr_data = '{traveler: trav_reg, remaining: rem_reg};
                            ns_wr_en    = 1'b1;
                            ns_wr_data  = '{occupied: 1'b1,
                                            length: ns.length + nla_pkg::LEN_W'(1)};
                            node_valid_next[node_a] = 1'b1;
                        end
                        else
                        begin
                            pend_ovf_next = 1'b1;
                        end
                    end
                    else if (ns.length == '0)
                    begin
                        ns_wr_en   = 1'b1;
                        ns_wr_data = '0;
                        node_valid_next[node_a] = 1'b1;
                    end
                    else
                    begin
                        ns_wr_en          = 1'b1;
                        ns_wr_data        = '{occupied: 1'b1,
                                              length: ns.length - nla_pkg::LEN_W'(1)};
                        node_valid_next[node_a] = 1'b1;
                        len_next          = ns.length;
                        scan_len_next     = (mode_reg == nla_pkg::MODE_SJF) ?
                                            ns.length : nla_pkg::LEN_W'(1);
                        pend_granted_next = 1'b1;
                        pend_node_next    = node_reg;
                        ent_rd_en         = 1'b1;
                        ent_rd_idx        = '0;
                        cmp_idx_next      = '0;
                        rd_idx_next       = nla_pkg::LEN_W'(1);
                        state_next        = nla_pkg::ST_SCAN;
                    end
                end
            end

            nla_pkg::ST_SCAN:
            begin
                best_idx_next  = sel_idx;
                best_rem_next  = scan_take ? entry_q.remaining : best_rem_reg;
                best_trav_next = sel_trav;
                if (rd_idx_reg < scan_len_reg)
                begin
                    ent_rd_en    = 1'b1;
                    ent_rd_idx   = rd_idx_reg[nla_pkg::QIDX_W-1:0];
                    rd_idx_next  = rd_idx_reg + nla_pkg::LEN_W'(1);
                    cmp_idx_next = rd_idx_reg;
                end
                else
                begin
                    pend_trav_next = sel_trav;
                    if (sel_next < len_reg)
                    begin
                        ent_rd_en   = 1'b1;
                        ent_rd_idx  = sel_next[nla_pkg::QIDX_W-1:0];
                        rd_idx_next = sel_next;
                        state_next  = nla_pkg::ST_SHIFT;
                    end
                    else
                    begin
                        state_next = nla_pkg::ST_DONE;
                    end
                end
            end

            nla_pkg::ST_SHIFT:
            begin
                ent_wr_en   = 1'b1;
                ent_wr_idx  = nla_pkg::QIDX_W'(rd_idx_reg - nla_pkg::LEN_W'(1));
                ent_wr_data = entry_q;
                if (shift_next < len_reg)
                begin
                    ent_rd_en   = 1'b1;
                    ent_rd_idx  = shift_next[nla_pkg::QIDX_W-1:0];
                    rd_idx_next = shift_next;
                end
                else
                begin
                    state_next = nla_pkg::ST_DONE;
                end
            end

            nla_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next      = 1'b1;
                    granted_next        = pend_granted_reg;
                    grant_traveler_next = pend_trav_reg;
                    grant_node_next     = pend_node_reg;
                    queue_overflow_next = pend_ovf_reg;
                    state_next          = nla_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = nla_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= nla_pkg::ST_IDLE;
            mode_reg       <= nla_pkg::MODE_FCFS;
            node_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_valid_reg <= node_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg  <= cmd;
            node_reg <= node;
            trav_reg <= traveler;
            rem_reg  <= remaining;
        end
        len_reg            <= len_next;
        scan_len_reg       <= scan_len_next;
        rd_idx_reg         <= rd_idx_next;
        cmp_idx_reg        <= cmp_idx_next;
        best_idx_reg       <= best_idx_next;
        best_rem_reg       <= best_rem_next;
        best_trav_reg      <= best_trav_next;
        pend_granted_reg   <= pend_granted_next;
        pend_trav_reg      <= pend_trav_next;
        pend_node_reg      <= pend_node_next;
        pend_ovf_reg       <= pend_ovf_next;
        granted_reg        <= granted_next;
        grant_traveler_reg <= grant_traveler_next;
        grant_node_reg     <= grant_node_next;
        queue_overflow_reg <= queue_overflow_next;
    end

    `NLA_ASSERT_NXT(a_xfer_to_node, in_xfer, state_reg == nla_pkg::ST_NODE)
    `NLA_ASSERT_IMP(a_grant_or_drop, out_valid_reg, !(granted_reg && queue_overflow_reg))
    `NLA_ASSERT_IMP(a_scan_in_queue, state_reg == nla_pkg::ST_SCAN, cmp_idx_reg < scan_len_reg)
    `NLA_ASSERT_IMP(a_shift_in_queue, state_reg == nla_pkg::ST_SHIFT, (rd_idx_reg < len_reg) && (rd_idx_reg != '0))

endmodule

@@ tb/sv/tb_top.sv @@
// ---------------------------------------------------------------------------
// Node lock arbiter testbench
// Sends enter and leave requests through the input channel and checks every
// grant against an in-bench model of the per-node locks and wait queues.
// Covers both hand-over orders, full queues, leaves of free nodes and
// random traffic on a few busy nodes, with random gaps on the input channel
// and random stalls on the output channel.
// ---------------------------------------------------------------------------
module tb_top;
    import nla_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic              granted;
        logic [TRAV_W-1:0] traveler;
        logic [NODE_IN_W-1:0] node;
        logic              overflow;
    } grant_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic                  cfg_wr_data = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  cmd = 1'b0;
    logic [NODE_IN_W-1:0]  node = '0;
    logic [TRAV_W-1:0]     traveler = '0;
    logic [REM_W-1:0]      remaining = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  granted;
    logic [TRAV_W-1:0]     grant_traveler;
    logic [NODE_IN_W-1:0]  grant_node;
    logic                  queue_overflow;

    logic                  mode_shadow;
    logic                  lock_held [NODE_COUNT];
    int                    wait_len [NODE_COUNT];
    logic [TRAV_W-1:0]     wait_trav [NODE_COUNT][QUEUE_DEPTH];
    logic [REM_W-1:0]      wait_rem [NODE_COUNT][QUEUE_DEPTH];

    grant_t                pending_grants [$];
    int                    errors = 0;
    int                    transfers_sent = 0;
    int                    grants_seen = 0;
    int                    overflows_seen = 0;
    int                    cycle_count = 0;
    bit                    gaps_on = 1'b1;
    bit                    stalls_on = 1'b1;

    node_lock_fcfs_sjf_arbiter u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .node           (node),
        .traveler       (traveler),
        .remaining      (remaining),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .granted        (granted),
        .grant_traveler (grant_traveler),
        .grant_node     (grant_node),
        .queue_overflow (queue_overflow)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int pick_run_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic int pick_remaining();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 127);
            1: return $urandom_range(0, 3);
            2: return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(64, 127);
            default: return $urandom_range(0, 70);
        endcase
    endfunction

    function automatic grant_t predict_lock_step(input logic c, input logic [NODE_IN_W-1:0] n,
                                                 input logic [TRAV_W-1:0] t,
                                                 input logic [REM_W-1:0] r);
        grant_t res;
        int     len;
        int     pick;
        int     i;
        res = '0;
        if (n < NODE_COUNT)
        begin
            if (c == CMD_ENTER)
            begin
                if (!lock_held[n])
                begin
                    lock_held[n] = 1'b1;
                    res.granted  = 1'b1;
                    res.traveler = t;
                    res.node     = n;
                end
                else if (wait_len[n] < QUEUE_DEPTH)
                begin
                    wait_trav[n][wait_len[n]] = t;
                    wait_rem[n][wait_len[n]]  = r;
                    wait_len[n]++;
                end
                else
                begin
                    res.overflow = 1'b1;
                end
            end
            else
            begin
                len = wait_len[n];
                if (len > 0)
                begin
                    pick = 0;
                    if (mode_shadow == MODE_SJF)
                    begin
                        for (i = 1; i < len; i++)
                        begin
                            if (wait_rem[n][i] < wait_rem[n][pick])
                                pick = i;
                        end
                    end
                    res.granted  = 1'b1;
                    res.traveler = wait_trav[n][pick];
                    res.node     = n;
                    for (i = pick; i < len - 1; i++)
                    begin
                        wait_trav[n][i] = wait_trav[n][i + 1];
                        wait_rem[n][i]  = wait_rem[n][i + 1];
                    end
                    wait_len[n]  = len - 1;
                    lock_held[n] = 1'b1;
                end
                else
                begin
                    lock_held[n] = 1'b0;
                end
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : grant_checker
        grant_t exp;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_grants.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual granted=%0d trav=%0d node=%0d ovf=%0d",
                         $time, granted, grant_traveler, grant_node, queue_overflow);
                errors++;
            end
            else
            begin
                exp = pending_grants.pop_front();
                check_field("granted", int'(exp.granted), int'(granted));
                check_field("grant_traveler", int'(exp.traveler), int'(grant_traveler));
                check_field("grant_node", int'(exp.node), int'(grant_node));
                check_field("queue_overflow", int'(exp.overflow), int'(queue_overflow));
            end
            if (granted)
                grants_seen++;
            if (queue_overflow)
                overflows_seen++;
        end
    end

    initial
    begin : stall_driver
        int run_left;
        run_left = 0;
        forever
        begin
            @(posedge clk);
            if (run_left > 0)
                run_left--;
            else if (!stalls_on || out_stall)
            begin
                out_stall <= 1'b0;
                run_left = $urandom_range(0, 6);
            end
            else
            begin
                run_left = pick_run_length();
                out_stall <= (run_left > 0);
            end
        end
    end

    task automatic send_item(input logic c, input logic [NODE_IN_W-1:0] n,
                             input logic [TRAV_W-1:0] t, input logic [REM_W-1:0] r);
        int gap;
        in_valid  <= 1'b1;
        cmd       <= c;
        node      <= n;
        traveler  <= t;
        remaining <= r;
        do
            @(posedge clk);
        while (in_stall);
        pending_grants.push_back(predict_lock_step(c, n, t, r));
        transfers_sent++;
        gap = gaps_on ? pick_run_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_sched_mode(input logic m);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mode_shadow = m;
        @(posedge clk);
    endtask

    task automatic test_directed_fcfs();
        set_sched_mode(MODE_FCFS);
        send_item(CMD_ENTER, 0, 0, 0);
        send_item(CMD_ENTER, 63, 31, 127);
        send_item(CMD_ENTER, 0, 31, 64);
        send_item(CMD_ENTER, 0, 5, 3);
        send_item(CMD_LEAVE, 0, 0, 0);
        send_item(CMD_LEAVE, 63, 31, 0);
        send_item(CMD_LEAVE, 63, 31, 0);
        send_item(CMD_ENTER, 63, 1, 1);
        send_item(CMD_LEAVE, 0, 9, 0);
        send_item(CMD_LEAVE, 0, 5, 0);
        send_item(CMD_ENTER, 10, 7, 20);
        send_item(CMD_ENTER, 10, 7, 20);
        send_item(CMD_LEAVE, 10, 7, 0);
    endtask

    task automatic test_directed_sjf();
        set_sched_mode(MODE_SJF);
        send_item(CMD_ENTER, 20, 1, 50);
        send_item(CMD_ENTER, 20, 2, 127);
        send_item(CMD_ENTER, 20, 3, 9);
        send_item(CMD_ENTER, 20, 4, 9);
        send_item(CMD_ENTER, 20, 5, 100);
        send_item(CMD_ENTER, 20, 6, 0);
        repeat (6) send_item(CMD_LEAVE, 20, 1, 0);
    endtask

    task automatic test_queue_overflow(input logic m, input bit idle_on);
        logic [NODE_IN_W-1:0] n;
        set_sched_mode(m);
        gaps_on   = idle_on;
        stalls_on = idle_on;
        n = NODE_IN_W'($urandom_range(0, NODE_COUNT - 1));
        while (wait_len[n] < QUEUE_DEPTH)
            send_item(CMD_ENTER, n, TRAV_W'($urandom_range(0, 31)), REM_W'(pick_remaining()));
        repeat ($urandom_range(2, 4))
            send_item(CMD_ENTER, n, TRAV_W'($urandom_range(0, 31)), REM_W'(pick_remaining()));
        while (wait_len[n] > 0)
            send_item(CMD_LEAVE, n, TRAV_W'($urandom_range(0, 31)), REM_W'(pick_remaining()));
        send_item(CMD_LEAVE, n, TRAV_W'($urandom_range(0, 31)), REM_W'(pick_remaining()));
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_random_traffic(input logic m, input int count, input int enter_pct,
                                       input bit stall_phase);
        logic [NODE_IN_W-1:0] busy [3];
        logic [NODE_IN_W-1:0] n;
        logic                 c;
        int                   i;
        set_sched_mode(m);
        stalls_on = stall_phase;
        foreach (busy[j])
            busy[j] = NODE_IN_W'($urandom_range(0, NODE_COUNT - 1));
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 79) == 0)
                busy[$urandom_range(0, 2)] = NODE_IN_W'($urandom_range(0, NODE_COUNT - 1));
            n = ($urandom_range(0, 99) < 85) ? busy[$urandom_range(0, 2)]
                                             : NODE_IN_W'($urandom_range(0, NODE_COUNT - 1));
            c = ($urandom_range(0, 99) < enter_pct) ? CMD_ENTER : CMD_LEAVE;
            send_item(c, n, TRAV_W'($urandom_range(0, 31)), REM_W'(pick_remaining()));
            if ($urandom_range(0, 49) == 0)
                wait_for_results();
        end
        stalls_on = 1'b1;
    endtask

    initial
    begin
        mode_shadow = MODE_FCFS;
        for (int j = 0; j < NODE_COUNT; j++)
        begin
            lock_held[j] = 1'b0;
            wait_len[j]  = 0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_fcfs();
        test_directed_sjf();
        test_queue_overflow(MODE_SJF, 1'b1);
        test_queue_overflow(MODE_FCFS, 1'b0);
        test_random_traffic(MODE_FCFS, 220, 55, 1'b1);
        test_random_traffic(MODE_SJF, 220, 65, 1'b0);
        test_random_traffic(MODE_FCFS, 200, 50, 1'b1);
        test_random_traffic(MODE_SJF, 240, 70, 1'b1);

        wait_for_results();
        repeat (2 * QUEUE_DEPTH + 8) @(posedge clk);
        $display("Run covered %0d transfers in both hand-over modes: %0d grants, %0d overflows.",
                 transfers_sent, grants_seen, overflows_seen);
        $display("Mismatches found: %0d", errors);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/nla_pkg.sv
design/nla_ram.sv
design/node_lock_fcfs_sjf_arbiter.sv
tb/sv/tb_top.sv
